[src/oledtf_pkg.sv]
// Shared types, command codes and the 5x7 glyph table for the OLED text frame store.
// No dependencies; the files that use this package refer to it by scoped names.
`default_nettype none
package oledtf_pkg;

  localparam int ENTRY_ADDR_W = 11;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [7:0] CTRL_PREFIX    = 8'h00;
  localparam logic [7:0] DATA_PREFIX    = 8'h40;
  localparam logic [7:0] PAGE_CMD_BASE  = 8'hB0;
  localparam logic [7:0] COL_HIGH_CMD   = 8'h10;
  localparam logic [7:0] COL_LOW_OFFSET = 8'h02;
  localparam logic [7:0] COL_LOW_PLAIN  = 8'h00;
  localparam logic [7:0] FILL_BYTE      = 8'hFF;
  localparam logic [7:0] BLANK_BYTE     = 8'h00;
  localparam logic [7:0] GLYPH_ADVANCE  = 8'd6;
  localparam logic [7:0] FIRST_CHAR     = 8'd32;
  localparam logic [7:0] LAST_CHAR      = 8'd126;
  localparam logic [7:0] FALLBACK_CHAR  = 8'h3F;

  typedef enum logic [2:0] {
    CMD_CLEAR       = 3'd0,
    CMD_FILL        = 3'd1,
    CMD_TEXT_START  = 3'd2,
    CMD_TEXT_CHAR   = 3'd3,
    CMD_FLUSH_START = 3'd4,
    CMD_PULL        = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LINE_ERR = 2'd1,
    ST_NO_FLUSH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_SWEEP,
    OP_GLYPH,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_GLYPH,
    BK_READ
  } back_state_t;

  typedef struct packed {
    op_t                     op;
    logic [7:0]              data;
    logic [6:0]              gidx;
    logic [ENTRY_ADDR_W-1:0] addr;
    status_t                 status;
    logic                    byte_valid;
    logic                    eot;
    logic                    last;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  localparam logic [39:0] GLYPH_ROM [0:94] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h0804081008
  };

  function automatic logic [7:0] glyph_col(input logic [6:0] idx, input logic [2:0] k);
    logic [39:0] row;
    logic [7:0]  col;
    row = (idx > 7'd94) ? 40'h0 : GLYPH_ROM[idx];
    case (k)
      3'd0: col = row[39:32];
      3'd1: col = row[31:24];
      3'd2: col = row[23:16];
      3'd3: col = row[15:8];
      3'd4: col = row[7:0];
      default: col = BLANK_BYTE;
    endcase
    return col;
  endfunction

endpackage
`default_nettype wire

[src/oled_text_framebuffer.sv]
// Top level: text frame store with glyph drawing and byte-serial flush stream.
// Depends on oledtf_pkg, oledtf_front, oledtf_queue, oledtf_back, oledtf_ram.
//
//   port group   handshake                    payload
//   in_          in_valid / in_ready          cmd, start_column, text_line, char_code, fill_on
//   out_         out_valid / out_ready        status, out_byte, byte_valid, end_of_transfer,
//                                             flush_last
//   config       psel, penable, pwrite        paddr, pwdata, prdata (column_offset_two at 0)
//
// A character is drawn in the back part as six byte writes into the byte-wide store.
// Clear and fill write every store byte, one store byte per cycle.
// A flush data byte is a registered store read; other flush bytes come with the entry.
// After reset the whole store is swept to zero with in_ready low; config writes are taken
// throughout.
// A two-entry queue takes words while the back part is busy or out_ready is low, until full.
`default_nettype none
module oled_text_framebuffer #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64,
  parameter int TEXT_LINES     = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [7:0]  in_start_column,
  input  wire logic [3:0]  in_text_line,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_fill_on,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_out_byte,
  output logic             out_byte_valid,
  output logic             out_end_of_transfer,
  output logic             out_flush_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic                    col_offset_r;
  logic                    accept;
  logic                    init_busy;
  oledtf_pkg::entry_t      new_entry, head;
  oledtf_pkg::queue_ctl_t  q_ctl;
  oledtf_pkg::queue_stat_t q_stat;
  logic                    pop;

  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? 32'd0 : {31'd0, col_offset_r};
  assign in_ready = !q_stat.full && !init_busy;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_offset_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      col_offset_r <= pwdata[0];
    end
  end

  oledtf_front #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .TEXT_LINES     (TEXT_LINES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .cmd          (in_cmd),
    .start_column (in_start_column),
    .text_line    (in_text_line),
    .char_code    (in_char_code),
    .fill_on      (in_fill_on),
    .col_offset   (col_offset_r),
    .entry        (new_entry)
  );

  assign q_ctl.push = accept;
  assign q_ctl.pop  = pop;

  oledtf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (q_ctl),
    .wr_entry (new_entry),
    .head     (head),
    .stat     (q_stat)
  );

  oledtf_back #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_empty        (q_stat.empty),
    .pop            (pop),
    .init_busy      (init_busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_byte       (out_out_byte),
    .out_byte_valid (out_byte_valid),
    .out_eot        (out_end_of_transfer),
    .out_last       (out_flush_last)
  );

endmodule
`default_nettype wire

[src/oledtf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module oledtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/oledtf_front.sv]
// Front part: accepts words, tracks text cursor and flush position, and builds work entries for the queue.
// Depends on oledtf_pkg.
`default_nettype none
module oledtf_front #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64,
  parameter int TEXT_LINES     = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [2:0]          cmd,
  input  wire logic [7:0]          start_column,
  input  wire logic [3:0]          text_line,
  input  wire logic [7:0]          char_code,
  input  wire logic                fill_on,
  input  wire logic                col_offset,
  output oledtf_pkg::entry_t       entry
);

  localparam int PAGE_COUNT = DISPLAY_HEIGHT / 8;
  localparam int POS_W      = $clog2(DISPLAY_WIDTH + 7);
  localparam int AW         = oledtf_pkg::ENTRY_ADDR_W;

  localparam logic [POS_W-1:0] POS_PAGE_PFX = POS_W'(0);
  localparam logic [POS_W-1:0] POS_PAGE_CMD = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LOW_PFX  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LOW_CMD  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_HIGH_PFX = POS_W'(4);
  localparam logic [POS_W-1:0] POS_HIGH_CMD = POS_W'(5);
  localparam logic [POS_W-1:0] POS_DATA_PFX = POS_W'(6);
  localparam logic [POS_W-1:0] POS_END      = POS_W'(DISPLAY_WIDTH + 6);

  logic [7:0]       cursor_col_r,  cursor_col_nxt;
  logic [2:0]       cursor_page_r, cursor_page_nxt;
  logic             text_active_r, text_active_nxt;
  logic             flush_active_r, flush_active_nxt;
  logic [2:0]       flush_page_r,  flush_page_nxt;
  logic [POS_W-1:0] flush_pos_r,   flush_pos_nxt;
  logic [7:0]       sel_char;
  logic             page_last;

  always_comb begin
    sel_char  = (char_code < oledtf_pkg::FIRST_CHAR || char_code > oledtf_pkg::LAST_CHAR) ?
                oledtf_pkg::FALLBACK_CHAR : char_code;
    page_last = ({1'b0, flush_page_r} + 4'd1) >= 4'(PAGE_COUNT);
  end

  always_comb begin
    cursor_col_nxt   = cursor_col_r;
    cursor_page_nxt  = cursor_page_r;
    text_active_nxt  = text_active_r;
    flush_active_nxt = flush_active_r;
    flush_page_nxt   = flush_page_r;
    flush_pos_nxt    = flush_pos_r;
    entry            = '0;
    entry.op         = oledtf_pkg::OP_NONE;
    entry.status     = oledtf_pkg::ST_OK;
    case (oledtf_pkg::cmd_t'(cmd))
      oledtf_pkg::CMD_CLEAR: begin
        entry.op   = oledtf_pkg::OP_SWEEP;
        entry.data = oledtf_pkg::BLANK_BYTE;
      end
      oledtf_pkg::CMD_FILL: begin
        entry.op   = oledtf_pkg::OP_SWEEP;
        entry.data = fill_on ? oledtf_pkg::FILL_BYTE : oledtf_pkg::BLANK_BYTE;
      end
      oledtf_pkg::CMD_TEXT_START: begin
        if (text_line >= 4'(TEXT_LINES)) begin
          entry.status    = oledtf_pkg::ST_LINE_ERR;
          text_active_nxt = 1'b0;
        end else begin
          cursor_col_nxt  = start_column;
          cursor_page_nxt = text_line[2:0];
          text_active_nxt = 1'b1;
        end
      end
      oledtf_pkg::CMD_TEXT_CHAR: begin
        if (text_active_r && cursor_col_r <= 8'(DISPLAY_WIDTH - 6)) begin
          if ({1'b0, cursor_page_r} < 4'(PAGE_COUNT)) begin
            entry.op   = oledtf_pkg::OP_GLYPH;
            entry.gidx = 7'(sel_char - oledtf_pkg::FIRST_CHAR);
            entry.addr = AW'(cursor_page_r) * AW'(DISPLAY_WIDTH) + AW'(cursor_col_r);
          end
          cursor_col_nxt = cursor_col_r + oledtf_pkg::GLYPH_ADVANCE;
        end
      end
      oledtf_pkg::CMD_FLUSH_START: begin
        flush_active_nxt = 1'b1;
        flush_page_nxt   = 3'd0;
        flush_pos_nxt    = '0;
      end
      oledtf_pkg::CMD_PULL: begin
        if (!flush_active_r) begin
          entry.status = oledtf_pkg::ST_NO_FLUSH;
        end else begin
          entry.byte_valid = 1'b1;
          case (flush_pos_r)
            POS_PAGE_PFX, POS_LOW_PFX, POS_HIGH_PFX: begin
              entry.data = oledtf_pkg::CTRL_PREFIX;
            end
            POS_PAGE_CMD: begin
              entry.data = oledtf_pkg::PAGE_CMD_BASE + 8'(flush_page_r);
              entry.eot  = 1'b1;
            end
            POS_LOW_CMD: begin
              entry.data = col_offset ? oledtf_pkg::COL_LOW_OFFSET : oledtf_pkg::COL_LOW_PLAIN;
              entry.eot  = 1'b1;
            end
            POS_HIGH_CMD: begin
              entry.data = oledtf_pkg::COL_HIGH_CMD;
              entry.eot  = 1'b1;
            end
            POS_DATA_PFX: begin
              entry.data = oledtf_pkg::DATA_PREFIX;
            end
            default: begin
              entry.op   = oledtf_pkg::OP_READ;
              entry.addr = AW'(flush_page_r) * AW'(DISPLAY_WIDTH) + AW'(flush_pos_r) - AW'(7);
              entry.eot  = (flush_pos_r == POS_END);
            end
          endcase
          if (flush_pos_r >= POS_END) begin
            flush_pos_nxt = '0;
            if (page_last) begin
              entry.last       = 1'b1;
              flush_active_nxt = 1'b0;
              flush_page_nxt   = 3'd0;
            end else begin
              flush_page_nxt = flush_page_r + 3'd1;
            end
          end else begin
            flush_pos_nxt = flush_pos_r + POS_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r   <= '0;
      cursor_page_r  <= '0;
      text_active_r  <= 1'b0;
      flush_active_r <= 1'b0;
      flush_page_r   <= '0;
      flush_pos_r    <= '0;
    end else if (accept) begin
      cursor_col_r   <= cursor_col_nxt;
      cursor_page_r  <= cursor_page_nxt;
      text_active_r  <= text_active_nxt;
      flush_active_r <= flush_active_nxt;
      flush_page_r   <= flush_page_nxt;
      flush_pos_r    <= flush_pos_nxt;
    end
  end

endmodule
`default_nettype wire

[src/oledtf_queue.sv]
// Short register queue of work entries between the front and back parts.
// Depends on oledtf_pkg.
`default_nettype none
module oledtf_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire oledtf_pkg::queue_ctl_t ctl,
  input  wire oledtf_pkg::entry_t  wr_entry,
  output oledtf_pkg::entry_t       head,
  output oledtf_pkg::queue_stat_t  stat
);

  localparam int PW = $clog2(oledtf_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(oledtf_pkg::QUEUE_DEPTH + 1);

  oledtf_pkg::entry_t slots_r [0:oledtf_pkg::QUEUE_DEPTH-1];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    head       = slots_r[rd_ptr_r];
    stat.full  = (count_r == CW'(oledtf_pkg::QUEUE_DEPTH));
    stat.empty = (count_r == '0);
    count_nxt  = count_r + CW'(ctl.push) - CW'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slots_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(oledtf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (ctl.pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(oledtf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

[src/oledtf_back.sv]
// Back part: runs queued entries against the frame store RAM and registers one result each.
// Depends on oledtf_pkg and oledtf_ram.
`default_nettype none
module oledtf_back #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire oledtf_pkg::entry_t  head,
  input  wire logic                q_empty,
  output logic                     pop,
  output logic                     init_busy,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_status,
  output logic [7:0]               out_byte,
  output logic                     out_byte_valid,
  output logic                     out_eot,
  output logic                     out_last
);

  localparam int STORE = DISPLAY_WIDTH * (DISPLAY_HEIGHT / 8);
  localparam int AW    = $clog2(STORE);

  oledtf_pkg::back_state_t state_r, state_nxt;
  oledtf_pkg::entry_t      cur_r, cur_nxt, load_src;
  logic [AW-1:0]           cnt_r, cnt_nxt;
  logic [2:0]              k_r, k_nxt;
  logic                    init_r, init_nxt;
  logic                    load;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [7:0]              ram_wdata, ram_rdata, load_byte;
  logic                    valid_r;
  logic [1:0]              status_r;
  logic [7:0]              byte_r;
  logic                    byte_valid_r, eot_r, last_r;

  oledtf_ram #(
    .WIDTH(8),
    .DEPTH(STORE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head.addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    init_nxt  = init_r;
    case (state_r)
      oledtf_pkg::BK_IDLE: begin
        if (!q_empty && !valid_r) begin
          cur_nxt = head;
          cnt_nxt = '0;
          k_nxt   = 3'd0;
          case (head.op)
            oledtf_pkg::OP_SWEEP: state_nxt = oledtf_pkg::BK_SWEEP;
            oledtf_pkg::OP_GLYPH: state_nxt = oledtf_pkg::BK_GLYPH;
            oledtf_pkg::OP_READ:  state_nxt = oledtf_pkg::BK_READ;
            default:              state_nxt = oledtf_pkg::BK_IDLE;
          endcase
        end
      end
      oledtf_pkg::BK_SWEEP: begin
        if (cnt_r == AW'(STORE - 1)) begin
          state_nxt = oledtf_pkg::BK_IDLE;
          init_nxt  = 1'b0;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      oledtf_pkg::BK_GLYPH: begin
        if (k_r == 3'd5) begin
          state_nxt = oledtf_pkg::BK_IDLE;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      oledtf_pkg::BK_READ: begin
        state_nxt = oledtf_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = oledtf_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    load      = 1'b0;
    load_src  = cur_r;
    load_byte = 8'd0;
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = cur_r.data;
    case (state_r)
      oledtf_pkg::BK_IDLE: begin
        load_src = head;
        if (!q_empty && !valid_r) begin
          pop = 1'b1;
          if (head.op == oledtf_pkg::OP_NONE) begin
            load      = 1'b1;
            load_byte = head.data;
          end
        end
      end
      oledtf_pkg::BK_SWEEP: begin
        ram_we = 1'b1;
        load   = (cnt_r == AW'(STORE - 1)) && !init_r;
      end
      oledtf_pkg::BK_GLYPH: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r.addr[AW-1:0] + AW'(k_r);
        ram_wdata = oledtf_pkg::glyph_col(cur_r.gidx, k_r);
        load      = (k_r == 3'd5);
      end
      oledtf_pkg::BK_READ: begin
        load      = 1'b1;
        load_byte = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oledtf_pkg::BK_SWEEP;
      cnt_r   <= '0;
      k_r     <= '0;
      init_r  <= 1'b1;
      cur_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      init_r  <= init_nxt;
      cur_r   <= cur_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r     <= load_src.status;
      byte_r       <= load_byte;
      byte_valid_r <= load_src.byte_valid;
      eot_r        <= load_src.eot;
      last_r       <= load_src.last;
    end
  end

  assign init_busy      = init_r;
  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = byte_valid_r;
  assign out_eot        = eot_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire
